// ===== rtl/core/ssf_pkg.sv =====
package ssf_pkg;

  // Sizing of the datapath
  localparam int unsigned ADC_BITS     = 12;
  localparam int unsigned TABLE_POINTS = 9;
  localparam int unsigned FRAME_LENGTH = 10;
  localparam int unsigned VU_W         = 22;  // microvolts, below 4.1e6
  localparam int unsigned DIV_NW       = 42;  // widest dividend: 800 * Rs
  localparam int unsigned DIV_DW       = 22;  // widest divisor: microvolts
  localparam int unsigned DIV_CW       = 6;   // iteration count, up to DIV_NW
  localparam int unsigned CNT_W        = 4;   // frame byte position
  localparam int unsigned IDX_W        = 4;   // table point index
  localparam int unsigned OHM_W        = 15;  // table resistance
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned Q_PTR_W      = 2;
  localparam int unsigned Q_CNT_W      = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  // Frame bytes
  localparam logic [7:0] FRAME_START = 8'd255;
  localparam logic [7:0] FRAME_END   = 8'd254;
  localparam logic [7:0] TYPE_CO     = 8'd10;
  localparam logic [7:0] TYPE_TEMP   = 8'd1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LENGTH - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VREF      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CO_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_CONST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES    = 3'd3;

  // Sample kind
  localparam logic KIND_CO   = 1'b0;
  localparam logic KIND_TEMP = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic            zero;
    logic [VU_W-1:0] vu;
  } item_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic       range_flag;
  } res_t;

  typedef struct packed {
    logic [15:0] co_ref;
    logic [15:0] div_const;
    logic [15:0] series;
  } cfg_t;

  // Thermistor table: resistance at each 10 degC point
  function automatic logic [OHM_W-1:0] tbl_ohm(input logic [IDX_W-1:0] idx);
    logic [OHM_W-1:0] r;
    case (idx)
      4'd0:    r = 15'd27900;
      4'd1:    r = 15'd18220;
      4'd2:    r = 15'd12120;
      4'd3:    r = 15'd8310;
      4'd4:    r = 15'd5800;
      4'd5:    r = 15'd4120;
      4'd6:    r = 15'd3000;
      4'd7:    r = 15'd2210;
      4'd8:    r = 15'd1660;
      default: r = 15'd1660;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tbl_deg(input logic [IDX_W-1:0] idx);
    logic [7:0] d;
    case (idx)
      4'd0:    d = 8'd0;
      4'd1:    d = 8'd10;
      4'd2:    d = 8'd20;
      4'd3:    d = 8'd30;
      4'd4:    d = 8'd40;
      4'd5:    d = 8'd50;
      4'd6:    d = 8'd60;
      4'd7:    d = 8'd70;
      4'd8:    d = 8'd80;
      default: d = 8'd80;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/ssf_div.sv =====
module ssf_div import ssf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  input  logic [DIV_CW-1:0] iters_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o,
  output logic              rem_nz_o
);

  logic              run_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, dvs_q;
  logic [DIV_DW:0]   rem_sh, diff;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_NW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= iters_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: align the dividend so the quotient ends in the low bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i << (DIV_CW'(DIV_NW) - iters_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// ===== rtl/core/ssf_front.sv =====
module ssf_front import ssf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                req_type_i,
  input  logic [ADC_BITS-1:0] raw_sample_i,
  input  logic [11:0]         vref_i,
  input  logic [Q_CNT_W-1:0]  q_count_i,
  output logic                busy_o,
  output logic                push_o,
  output item_t               push_data_o
);

  logic          s1_valid_q, s1_type_q;
  logic [23:0]   s1_prod_q;
  logic [33:0]   vu_full;
  logic          accept;

  // Hold off new transactions while the queue and the stage cannot take them
  assign busy_o = ({1'b0, q_count_i} + {{Q_CNT_W{1'b0}}, s1_valid_q}) >= (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept = start_i && !busy_o;

  // Stage one: sample times reference
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q <= req_type_i;
      s1_prod_q <= {12'd0, raw_sample_i} * {12'd0, vref_i};
    end
  end

  // Scale to microvolts and classify
  assign vu_full = ({10'd0, s1_prod_q} * 34'd1000) >> ADC_BITS;

  always_comb begin
    push_o               = s1_valid_q;
    push_data_o.req_type = s1_type_q;
    push_data_o.vu       = vu_full[VU_W-1:0];
    push_data_o.zero     = (vu_full[VU_W-1:0] == '0);
  end

endmodule

// ===== rtl/core/ssf_queue.sv =====
module ssf_queue import ssf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  item_t              push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output item_t              head_o,
  output logic [Q_CNT_W-1:0] count_o
);

  item_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_q, rd_q;
  logic [Q_CNT_W-1:0]  cnt_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + Q_PTR_W'(1);
      if (pop_i)  rd_q <= rd_q + Q_PTR_W'(1);
      cnt_q <= cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== rtl/core/ssf_engine.sv =====
module ssf_engine import ssf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_head_i,
  output logic  q_pop_o,
  input  cfg_t  cfg_i,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_CO_DIV1, S_CO_DIV2, S_TMP_DIV1, S_TMP_SEG, S_TMP_DIV2, S_OUT
  } state_e;

  state_e            state_q;
  res_t              res_q;
  logic signed [36:0] rt_q;
  logic [IDX_W-1:0]  seg_q;

  logic              div_start, div_done, div_rem_nz;
  logic [DIV_NW-1:0] div_n, div_quot;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_CW-1:0] div_it;

  logic [15:0]       r0_eff;
  logic [DIV_NW-1:0] co_n1, tmp_n1, co_n2;
  logic              rt_hi, rt_lo;
  logic [IDX_W-1:0]  seg_k;
  logic [OHM_W-1:0]  seg_diff, seg_span;
  logic [15:0]       ppm;
  logic [7:0]        deg;

  ssf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .iters_i    (div_it),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  // Operands of each division
  always_comb begin
    r0_eff = (cfg_i.co_ref == '0) ? 16'd1 : cfg_i.co_ref;
    co_n1  = DIV_NW'({19'd0, 23'd5000000 - {1'b0, q_head_i.vu}}) * DIV_NW'(1000);
    tmp_n1 = DIV_NW'(cfg_i.div_const) * DIV_NW'(1000000);
    co_n2  = (div_quot << 9) + (div_quot << 8) + (div_quot << 5);
  end

  // Locate the table segment that holds the resistance
  always_comb begin
    rt_hi = rt_q > 37'sd27900;
    rt_lo = rt_q < 37'sd1660;
    seg_k = '0;
    for (int j = 0; j < TABLE_POINTS - 1; j++) begin
      if ($signed({22'd0, tbl_ohm(IDX_W'(j))}) > rt_q) seg_k = seg_k + IDX_W'(1);
    end
    seg_diff = rt_q[OHM_W-1:0] - tbl_ohm(seg_k);
    seg_span = tbl_ohm(seg_k - IDX_W'(1)) - tbl_ohm(seg_k);
  end

  // Final value from the last quotient
  always_comb begin
    if (div_quot == DIV_NW'(1640)) ppm = 16'd0;
    else ppm = 16'd1640 - div_quot[15:0] - 16'(div_rem_nz);
    deg = tbl_deg(seg_q) - div_quot[7:0] - 8'(div_rem_nz);
  end

  // Division launch
  always_comb begin
    div_start = 1'b0;
    div_n     = co_n1;
    div_d     = q_head_i.vu;
    div_it    = DIV_CW'(33);
    q_pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && !q_head_i.zero) begin
          div_start = 1'b1;
          if (q_head_i.req_type == KIND_TEMP) begin
            div_n  = tmp_n1;
            div_it = DIV_CW'(36);
          end
        end
      end
      S_CO_DIV1: begin
        div_start = div_done;
        div_n     = co_n2;
        div_d     = DIV_DW'(r0_eff);
        div_it    = DIV_CW'(42);
      end
      S_TMP_SEG: begin
        div_start = !rt_hi && !rt_lo && (seg_k != '0);
        div_n     = DIV_NW'({seg_diff, 3'b000}) + DIV_NW'({seg_diff, 1'b0});
        div_d     = DIV_DW'(seg_span);
        div_it    = DIV_CW'(17);
      end
      default: ;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      rt_q    <= '0;
      seg_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            res_q.req_type   <= q_head_i.req_type;
            res_q.data_a     <= '0;
            res_q.data_b     <= '0;
            res_q.range_flag <= q_head_i.zero;
            if (q_head_i.zero) state_q <= S_OUT;
            else if (q_head_i.req_type == KIND_TEMP) state_q <= S_TMP_DIV1;
            else state_q <= S_CO_DIV1;
          end
        end
        S_CO_DIV1: begin
          if (div_done) state_q <= S_CO_DIV2;
        end
        S_CO_DIV2: begin
          if (div_done) begin
            if (div_quot >= DIV_NW'(1641)) begin
              res_q.range_flag <= 1'b1;
            end else begin
              res_q.data_a <= ppm[15:8];
              res_q.data_b <= ppm[7:0];
            end
            state_q <= S_OUT;
          end
        end
        S_TMP_DIV1: begin
          if (div_done) begin
            rt_q    <= $signed({1'b0, div_quot[35:0]}) - $signed({21'd0, cfg_i.series});
            state_q <= S_TMP_SEG;
          end
        end
        S_TMP_SEG: begin
          seg_q <= seg_k;
          if (rt_hi) begin
            res_q.range_flag <= 1'b1;
            state_q          <= S_OUT;
          end else if (rt_lo) begin
            res_q.range_flag <= 1'b1;
            res_q.data_a     <= tbl_deg(IDX_W'(TABLE_POINTS - 1));
            state_q          <= S_OUT;
          end else if (seg_k == '0) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_TMP_DIV2;
          end
        end
        S_TMP_DIV2: begin
          if (div_done) begin
            res_q.data_a <= deg;
            state_q      <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

endmodule

// ===== rtl/core/ssf_framer.sv =====
module ssf_framer import ssf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  res_t       res_i,
  output logic       res_ready_o,
  output logic       frame_valid_o,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o,
  output logic       range_flag_o
);

  logic             active_q;
  logic [CNT_W-1:0] cnt_q;
  res_t             cur_q;
  logic             load;

  // Take the next result while idle or on the final byte of the current frame
  assign res_ready_o = !active_q || (cnt_q == LAST_POS);
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        if (cnt_q == LAST_POS) active_q <= 1'b0;
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= res_i;
  end

  // Select the byte for this position
  always_comb begin
    if (cnt_q == LAST_POS) frame_byte_o = FRAME_END;
    else if (cnt_q == CNT_W'(0)) frame_byte_o = FRAME_START;
    else if (cnt_q == CNT_W'(1)) frame_byte_o = cur_q.req_type ? TYPE_TEMP : TYPE_CO;
    else if (cnt_q == CNT_W'(2)) frame_byte_o = cur_q.data_a;
    else if (cnt_q == CNT_W'(3)) frame_byte_o = cur_q.data_b;
    else frame_byte_o = 8'd0;
  end

  assign frame_valid_o = active_q;
  assign last_byte_o   = active_q && (cnt_q == LAST_POS);
  assign range_flag_o  = cur_q.range_flag;

endmodule

// ===== rtl/core/sensor_sample_to_frame.sv =====
// Channel | Direction | Handshake            | Payload
// sample  | in        | start_i, busy_o      | req_type_i, raw_sample_i
// frame   | out       | frame_valid_o strobe | frame_byte_o, last_byte_o, range_flag_o
// config  | in        | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// Each sample gives a ten-byte frame, one byte per cycle with no gaps inside a frame.
// Work per sample goes through one shared one-bit-per-cycle divider: a CO sample takes two
// divisions of 33 and 42 iterations and a temperature sample 36 and 17, only the first when
// it lands off the table; a zero sample needs no division. A four-entry queue buffers samples.
// Reset is asynchronous; registers return to their default values, queue and frame empty.
// The receiver cannot stall; busy_o rises when the queue and the front stage hold four.
module sensor_sample_to_frame import ssf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [11:0]           raw_sample_i,
  output logic                  frame_valid_o,
  output logic [7:0]            frame_byte_o,
  output logic                  last_byte_o,
  output logic                  range_flag_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [11:0]        vref_q;
  cfg_t               cfg_q;
  logic               push, pop, q_valid, res_valid, res_ready;
  item_t              push_data, q_head;
  logic [Q_CNT_W-1:0] q_count;
  res_t               res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q          <= 12'd2720;
      cfg_q.co_ref    <= 16'd5041;
      cfg_q.div_const <= 16'd4368;
      cfg_q.series    <= 16'd910;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VREF:      vref_q          <= cfg_wdata_i[11:0];
        CFG_CO_REF:    cfg_q.co_ref    <= cfg_wdata_i;
        CFG_DIV_CONST: cfg_q.div_const <= cfg_wdata_i;
        CFG_SERIES:    cfg_q.series    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ssf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_type_i   (req_type_i),
    .raw_sample_i (raw_sample_i),
    .vref_i       (vref_q),
    .q_count_i    (q_count),
    .busy_o       (busy_o),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  ssf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  ssf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (pop),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  ssf_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .res_ready_o   (res_ready),
    .frame_valid_o (frame_valid_o),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o),
    .range_flag_o  (range_flag_o)
  );

endmodule

// ===== rtl/core/ssf_checker.sv =====
module ssf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       frame_valid_o,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o,
  input logic       range_flag_o
);

  // Final byte marker only with a valid byte
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> frame_valid_o) else $error("last byte without strobe");

  // Final byte carries the end marker
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && last_byte_o |-> frame_byte_o == 8'd254)
    else $error("last byte is not the end marker");

  // A frame runs without gaps and keeps its flag
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !last_byte_o |=> frame_valid_o && $stable(range_flag_o))
    else $error("gap or flag change inside a frame");

  // A frame that follows directly opens with the start marker
  a_next_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && last_byte_o |=> !frame_valid_o || frame_byte_o == 8'd255)
    else $error("frame does not open with the start marker");

endmodule

bind sensor_sample_to_frame ssf_checker u_ssf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .frame_valid_o (frame_valid_o),
  .frame_byte_o  (frame_byte_o),
  .last_byte_o   (last_byte_o),
  .range_flag_o  (range_flag_o)
);
